@@ sv/sbpa_pkg.sv @@
package sbpa_pkg;

    // Default block counts of the four size classes.
    localparam int DEF_BIG_COUNT    = 10;
    localparam int DEF_MIDDLE_COUNT = 40;
    localparam int DEF_SMALL_COUNT  = 80;
    localparam int DEF_TINY_COUNT   = 160;

    // Bitmap geometry.
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int INDEX_W   = 8;
    localparam int WCNT_W    = INDEX_W - BIT_W;
    localparam int COUNT_W   = INDEX_W + 1;
    localparam int OFFSET_W  = 16;

    // Request modes.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_RANGE     = 2'd2;

    // Size class codes.
    localparam logic [1:0] CLS_BIG    = 2'd0;
    localparam logic [1:0] CLS_MIDDLE = 2'd1;
    localparam logic [1:0] CLS_SMALL  = 2'd2;
    localparam logic [1:0] CLS_TINY   = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [1:0]         size_class;
        logic [INDEX_W-1:0] free_index;
    } t_req;

    typedef struct packed {
        logic [1:0]          status;
        logic [INDEX_W-1:0]  block_index;
        logic [OFFSET_W-1:0] pool_offset;
    } t_rsp;

    // Control handed to the word scan unit.
    typedef struct packed {
        logic             mode;
        logic [BIT_W-1:0] free_bit;
    } t_word_ctl;

    // What the word scan unit reports back.
    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] first_bit;
    } t_word_sts;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

endpackage

@@ sv/sbpa_bitmap.sv @@
module sbpa_bitmap #(
    parameter int WORDS  = 11,
    parameter int ADDR_W = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ADDR_W-1:0]               i_addr,
    input  logic                            i_we,
    input  logic [sbpa_pkg::WORD_BITS-1:0]  i_wdata,
    output logic [sbpa_pkg::WORD_BITS-1:0]  o_rdata
);

    logic [sbpa_pkg::WORD_BITS-1:0] r_words [WORDS];

    // Used bitmap words; reset marks every block free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WORDS; k++) begin
                r_words[k] <= '0;
            end
        end else if (i_we && (32'(i_addr) < 32'(WORDS))) begin
            r_words[i_addr] <= i_wdata;
        end
    end

    // An address past the last word reads as fully used.
    always_comb begin
        if (32'(i_addr) < 32'(WORDS)) begin
            o_rdata = r_words[i_addr];
        end else begin
            o_rdata = '1;
        end
    end

endmodule

@@ sv/sbpa_word_unit.sv @@
module sbpa_word_unit (
    input  logic [sbpa_pkg::WORD_BITS-1:0] i_word,
    input  logic [sbpa_pkg::WORD_BITS-1:0] i_valid_mask,
    input  sbpa_pkg::t_word_ctl            i_ctl,
    output sbpa_pkg::t_word_sts            o_sts,
    output logic [sbpa_pkg::WORD_BITS-1:0] o_word
);

    logic [sbpa_pkg::WORD_BITS-1:0] free_bits;
    logic [sbpa_pkg::BIT_W-1:0]     first;

    // Free bits among the real blocks of this word.
    assign free_bits = ~i_word & i_valid_mask;

    // Lowest free bit, searched from the top down so the lowest wins.
    always_comb begin
        first = '0;
        for (int k = sbpa_pkg::WORD_BITS - 1; k >= 0; k--) begin
            if (free_bits[k]) begin
                first = sbpa_pkg::BIT_W'(k);
            end
        end
    end

    assign o_sts.found     = |free_bits;
    assign o_sts.first_bit = first;

    // Updated word: set the granted bit or clear the released one.
    always_comb begin
        if (i_ctl.mode == sbpa_pkg::MODE_ALLOC) begin
            o_word = i_word | (sbpa_pkg::WORD_BITS'(1) << first);
        end else begin
            o_word = i_word & ~(sbpa_pkg::WORD_BITS'(1) << i_ctl.free_bit);
        end
    end

endmodule

@@ sv/segregated_block_pool_allocator_unit.sv @@
// Fixed-block pool allocator with four size classes (1024, 512, 256 and 64
// bytes) laid out back to back in one pool. An allocate request grants the
// lowest free block of its class and returns the block index and the byte
// offset in the pool, or reports the class exhausted; a free request clears
// the used bit of the named block, or reports an index out of range. The used
// bitmap is kept in 32-bit words, each class starting on a fresh word, and is
// all free after reset. A sequencer walks the class one word per cycle through
// a shared find-first-free unit; an allocate scans at most ceil(count / 32)
// words of its class. Each result is registered in the sequencer and moves
// into the output register once that register is open; the next request is
// taken only after the result is loaded and the sequencer is idle again.
// Requests are taken one at a time; a new request is accepted while the
// previous result still waits in the output register, and its own result
// then waits in the sequencer until that register is taken.
module segregated_block_pool_allocator_unit #(
    parameter int BIG_COUNT    = sbpa_pkg::DEF_BIG_COUNT,
    parameter int MIDDLE_COUNT = sbpa_pkg::DEF_MIDDLE_COUNT,
    parameter int SMALL_COUNT  = sbpa_pkg::DEF_SMALL_COUNT,
    parameter int TINY_COUNT   = sbpa_pkg::DEF_TINY_COUNT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sbpa_pkg::t_req i_req,
    output logic           o_valid,
    input  logic           i_stall,
    output sbpa_pkg::t_rsp o_rsp
);

    localparam int BIG_WORDS    = (BIG_COUNT + 31) / 32;
    localparam int MIDDLE_WORDS = (MIDDLE_COUNT + 31) / 32;
    localparam int SMALL_WORDS  = (SMALL_COUNT + 31) / 32;
    localparam int TINY_WORDS   = (TINY_COUNT + 31) / 32;
    localparam int TOTAL_WORDS  = BIG_WORDS + MIDDLE_WORDS + SMALL_WORDS + TINY_WORDS;
    localparam int ADDR_W       = $clog2(TOTAL_WORDS);

    localparam int MIDDLE_WBASE = BIG_WORDS;
    localparam int SMALL_WBASE  = BIG_WORDS + MIDDLE_WORDS;
    localparam int TINY_WBASE   = BIG_WORDS + MIDDLE_WORDS + SMALL_WORDS;

    localparam int MIDDLE_BBASE = BIG_COUNT * 1024;
    localparam int SMALL_BBASE  = MIDDLE_BBASE + MIDDLE_COUNT * 512;
    localparam int TINY_BBASE   = SMALL_BBASE + SMALL_COUNT * 256;

    localparam int CW = sbpa_pkg::COUNT_W;
    localparam int WW = sbpa_pkg::WCNT_W;
    localparam int IW = sbpa_pkg::INDEX_W;
    localparam int BW = sbpa_pkg::WORD_BITS;

    sbpa_pkg::t_state r_state, n_state;
    sbpa_pkg::t_req   r_req,   n_req;
    sbpa_pkg::t_rsp   r_res,   n_res;
    sbpa_pkg::t_rsp   r_out,   n_out;
    logic             r_out_valid, n_out_valid;
    logic [WW-1:0]    r_wcnt,  n_wcnt;

    logic [CW-1:0]     cls_count;
    logic [ADDR_W-1:0] cls_wbase;
    logic [WW-1:0]     cls_last;
    logic [31:0]       cls_bbase;
    logic [3:0]        cls_shift;

    logic [ADDR_W-1:0] bm_addr;
    logic              bm_we;
    logic [BW-1:0]     bm_rdata;
    logic [BW-1:0]     bm_wdata;
    logic [BW-1:0]     valid_mask;
    logic [CW-1:0]     remaining;
    logic              free_in_range;
    logic [IW-1:0]     grant_index;
    logic [31:0]       grant_offset;
    logic              in_accept;
    logic              out_load;

    sbpa_pkg::t_word_ctl word_ctl;
    sbpa_pkg::t_word_sts word_sts;

    // Per-class geometry of the request in progress.
    always_comb begin
        unique case (r_req.size_class)
            sbpa_pkg::CLS_BIG: begin
                cls_count = CW'(BIG_COUNT);
                cls_wbase = '0;
                cls_last  = WW'(BIG_WORDS - 1);
                cls_bbase = '0;
                cls_shift = 4'd10;
            end
            sbpa_pkg::CLS_MIDDLE: begin
                cls_count = CW'(MIDDLE_COUNT);
                cls_wbase = ADDR_W'(MIDDLE_WBASE);
                cls_last  = WW'(MIDDLE_WORDS - 1);
                cls_bbase = 32'(MIDDLE_BBASE);
                cls_shift = 4'd9;
            end
            sbpa_pkg::CLS_SMALL: begin
                cls_count = CW'(SMALL_COUNT);
                cls_wbase = ADDR_W'(SMALL_WBASE);
                cls_last  = WW'(SMALL_WORDS - 1);
                cls_bbase = 32'(SMALL_BBASE);
                cls_shift = 4'd8;
            end
            default: begin
                cls_count = CW'(TINY_COUNT);
                cls_wbase = ADDR_W'(TINY_WBASE);
                cls_last  = WW'(TINY_WORDS - 1);
                cls_bbase = 32'(TINY_BBASE);
                cls_shift = 4'd6;
            end
        endcase
    end

    // Word address and the mask of real blocks in that word.
    assign bm_addr   = cls_wbase + ADDR_W'(r_wcnt);
    assign remaining = cls_count - CW'({r_wcnt, sbpa_pkg::BIT_W'(0)});
    always_comb begin
        if (remaining >= CW'(BW)) begin
            valid_mask = '1;
        end else begin
            valid_mask = (BW'(1) << remaining[sbpa_pkg::BIT_W-1:0]) - BW'(1);
        end
    end

    assign free_in_range = {1'b0, r_req.free_index} < cls_count;

    assign word_ctl.mode     = r_req.mode;
    assign word_ctl.free_bit = r_req.free_index[sbpa_pkg::BIT_W-1:0];

    sbpa_word_unit u_word (
        .i_word       (bm_rdata),
        .i_valid_mask (valid_mask),
        .i_ctl        (word_ctl),
        .o_sts        (word_sts),
        .o_word       (bm_wdata)
    );

    sbpa_bitmap #(
        .WORDS  (TOTAL_WORDS),
        .ADDR_W (ADDR_W)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (bm_addr),
        .i_we    (bm_we),
        .i_wdata (bm_wdata),
        .o_rdata (bm_rdata)
    );

    // Granted block index and its pool offset.
    assign grant_index  = {r_wcnt, word_sts.first_bit};
    assign grant_offset = cls_bbase + (32'(grant_index) << cls_shift);

    assign in_accept = i_valid && !o_stall;
    assign out_load  = (r_state == sbpa_pkg::S_DONE) && (!r_out_valid || !i_stall);
    assign o_stall   = (r_state != sbpa_pkg::S_IDLE);

    // Sequencer: accept, scan or update the bitmap, then hand off the result.
    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_res   = r_res;
        n_wcnt  = r_wcnt;
        bm_we   = 1'b0;
        unique case (r_state)
            sbpa_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_req   = i_req;
                    n_state = sbpa_pkg::S_RUN;
                    if (i_req.mode == sbpa_pkg::MODE_FREE) begin
                        n_wcnt = i_req.free_index[IW-1:sbpa_pkg::BIT_W];
                    end else begin
                        n_wcnt = '0;
                    end
                end
            end
            sbpa_pkg::S_RUN: begin
                n_res = '0;
                if (r_req.mode == sbpa_pkg::MODE_FREE) begin
                    n_state = sbpa_pkg::S_DONE;
                    if (free_in_range) begin
                        bm_we = 1'b1;
                    end else begin
                        n_res.status = sbpa_pkg::ST_RANGE;
                    end
                end else if (word_sts.found) begin
                    bm_we             = 1'b1;
                    n_res.block_index = grant_index;
                    n_res.pool_offset = grant_offset[sbpa_pkg::OFFSET_W-1:0];
                    n_state           = sbpa_pkg::S_DONE;
                end else if (r_wcnt == cls_last) begin
                    n_res.status = sbpa_pkg::ST_EXHAUSTED;
                    n_state      = sbpa_pkg::S_DONE;
                end else begin
                    n_wcnt = r_wcnt + WW'(1);
                end
            end
            sbpa_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = sbpa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sbpa_pkg::S_IDLE;
            end
        endcase
    end

    // Output register between the sequencer and the consumer.
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sbpa_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_res  <= n_res;
        r_out  <= n_out;
        r_wcnt <= n_wcnt;
    end

    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

`ifndef SYNTHESIS
    // An allocate scan never runs past the last word of its class.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sbpa_pkg::S_RUN) && (r_req.mode == sbpa_pkg::MODE_ALLOC))
            |-> (r_wcnt <= cls_last))
        else $error("allocate scan past the last word of its class");

    // A failed request carries a zero index and offset.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != sbpa_pkg::ST_OK))
            |-> ((o_rsp.block_index == '0) && (o_rsp.pool_offset == '0)))
        else $error("failed request with nonzero index or offset");

    // A new result appears only after the sequencer has finished a request.
    a_load_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == sbpa_pkg::S_DONE))
        else $error("result presented without a finished request");
`endif

endmodule

@@ bench/segregated_block_pool_allocator_unit_tb.sv @@
`timescale 1ns / 100ps

module segregated_block_pool_allocator_unit_tb;

    localparam int RANDOM_REQS = 400;
    localparam int HOLD_AFTER  = 60;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 16;
    localparam int REPORT_MAX  = 10;

    // Tracks the used bitmap of every size class and the responses still owed.
    class pool_scoreboard;
        bit [255:0]     used_map [4];
        sbpa_pkg::t_rsp pending_rsp [$];
        int             mismatches;
        bit             failed;

        static function int blocks_in(logic [1:0] cls);
            case (cls)
                sbpa_pkg::CLS_BIG:    return sbpa_pkg::DEF_BIG_COUNT;
                sbpa_pkg::CLS_MIDDLE: return sbpa_pkg::DEF_MIDDLE_COUNT;
                sbpa_pkg::CLS_SMALL:  return sbpa_pkg::DEF_SMALL_COUNT;
                default:              return sbpa_pkg::DEF_TINY_COUNT;
            endcase
        endfunction

        static function int block_bytes(logic [1:0] cls);
            case (cls)
                sbpa_pkg::CLS_BIG:    return 1024;
                sbpa_pkg::CLS_MIDDLE: return 512;
                sbpa_pkg::CLS_SMALL:  return 256;
                default:              return 64;
            endcase
        endfunction

        // Byte offset where a class starts; the classes sit back to back.
        static function int class_base(logic [1:0] cls);
            case (cls)
                sbpa_pkg::CLS_BIG:    return 0;
                sbpa_pkg::CLS_MIDDLE: return sbpa_pkg::DEF_BIG_COUNT * 1024;
                sbpa_pkg::CLS_SMALL:  return sbpa_pkg::DEF_BIG_COUNT * 1024
                                             + sbpa_pkg::DEF_MIDDLE_COUNT * 512;
                default:              return sbpa_pkg::DEF_BIG_COUNT * 1024
                                             + sbpa_pkg::DEF_MIDDLE_COUNT * 512
                                             + sbpa_pkg::DEF_SMALL_COUNT * 256;
            endcase
        endfunction

        function new();
            for (int c = 0; c < 4; c++) begin
                used_map[c] = '0;
            end
            mismatches = 0;
            failed     = 1'b0;
        endfunction

        // Applies one request to the bitmap and returns the response it earns.
        function sbpa_pkg::t_rsp grant_result(sbpa_pkg::t_req r);
            sbpa_pkg::t_rsp res;
            int             cnt;
            int             idx;
            res = '0;
            cnt = blocks_in(r.size_class);
            if (r.mode == sbpa_pkg::MODE_ALLOC) begin
                idx = 0;
                while (idx < cnt && used_map[r.size_class][idx]) begin
                    idx++;
                end
                if (idx < cnt) begin
                    used_map[r.size_class][idx] = 1'b1;
                    res.status      = sbpa_pkg::ST_OK;
                    res.block_index = sbpa_pkg::INDEX_W'(idx);
                    res.pool_offset = sbpa_pkg::OFFSET_W'(class_base(r.size_class)
                                          + idx * block_bytes(r.size_class));
                end else begin
                    res.status = sbpa_pkg::ST_EXHAUSTED;
                end
            end else begin
                if (int'(r.free_index) < cnt) begin
                    used_map[r.size_class][r.free_index] = 1'b0;
                    res.status = sbpa_pkg::ST_OK;
                end else begin
                    res.status = sbpa_pkg::ST_RANGE;
                end
            end
            return res;
        endfunction

        function void note_req(sbpa_pkg::t_req r);
            pending_rsp.push_back(grant_result(r));
        endfunction

        function void flag(string msg);
            failed = 1'b1;
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
                $display("%s", msg);
            end
        endfunction

        // Compares one accepted response with the oldest one owed.
        function void check_rsp(sbpa_pkg::t_rsp got);
            sbpa_pkg::t_rsp want;
            if (pending_rsp.size() == 0) begin
                flag($sformatf("response with no request pending: status %0d index %0d offset %0d",
                               got.status, got.block_index, got.pool_offset));
                return;
            end
            want = pending_rsp.pop_front();
            if (got.status != want.status || got.block_index != want.block_index
                    || got.pool_offset != want.pool_offset) begin
                flag($sformatf({"response mismatch: status %0d/%0d index %0d/%0d ",
                                "offset %0d/%0d (expected/actual)"},
                               want.status, got.status, want.block_index, got.block_index,
                               want.pool_offset, got.pool_offset));
            end
        endfunction
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    sbpa_pkg::t_req i_req;
    logic           o_valid;
    logic           i_stall;
    sbpa_pkg::t_rsp o_rsp;

    pool_scoreboard sb;
    int             req_count;
    bit             held_long;

    segregated_block_pool_allocator_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    // Mostly short gaps, now and then a long one; none at all in a calm stretch.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 40) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 30);
    endfunction

    function automatic sbpa_pkg::t_req req_of(logic mode, logic [1:0] cls,
                                              logic [sbpa_pkg::INDEX_W-1:0] idx);
        sbpa_pkg::t_req r;
        r.mode       = mode;
        r.size_class = cls;
        r.free_index = idx;
        return r;
    endfunction

    // Offers one request after an idle gap and holds it until it is taken.
    task automatic push_req(input sbpa_pkg::t_req r, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        sb.note_req(r);
        req_count++;
    endtask

    // Check every response taken by the receiving side.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_rsp(o_rsp);
        end
    end

    // Receiving side: random stalls, calm stretches and one long hold.
    initial begin
        int gap;
        int calm_left;
        calm_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_long && req_count >= HOLD_AFTER) begin
                held_long = 1'b1;
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                if (calm_left > 0) begin
                    calm_left--;
                    gap = 0;
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        calm_left = $urandom_range(10, 40);
                    end
                    gap = pick_gap(1'b0);
                end
                if (gap > 0) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Stimulus and end of run.
    initial begin
        int         sent;
        int         kind;
        int         len;
        int         cnt;
        bit         calm;
        logic [1:0] cls;
        logic       mode;
        logic [7:0] idx;

        sb        = new();
        req_count = 0;
        held_long = 1'b0;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_req     = '0;
        i_stall   = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Fill the big class until it reports exhausted.
        for (int k = 0; k <= sbpa_pkg::DEF_BIG_COUNT; k++) begin
            push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_BIG, 8'(k)), pick_gap(1'b0));
        end
        // Free and reallocate, range errors, freeing a block already free.
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_BIG, 8'd9), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_BIG,
                        8'(sbpa_pkg::DEF_BIG_COUNT)), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_BIG, 8'd0), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_TINY, 8'd255), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_TINY,
                        8'(sbpa_pkg::DEF_TINY_COUNT - 1)), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_TINY, 8'd255), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_MIDDLE, 8'd0), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_SMALL, 8'd0), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_MIDDLE,
                        8'(sbpa_pkg::DEF_MIDDLE_COUNT)), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_SMALL,
                        8'(sbpa_pkg::DEF_SMALL_COUNT)), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_SMALL,
                        8'(sbpa_pkg::DEF_SMALL_COUNT - 1)), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_BIG, 8'd0), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_FREE, sbpa_pkg::CLS_BIG, 8'd3), pick_gap(1'b0));
        push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_BIG, 8'd0), pick_gap(1'b0));

        // Run the tiny class to exhaustion back to back; the long output hold
        // lands in here and backs the block up.
        sent = 0;
        for (int k = 0; k < sbpa_pkg::DEF_TINY_COUNT + 2; k++) begin
            push_req(req_of(sbpa_pkg::MODE_ALLOC, sbpa_pkg::CLS_TINY, 8'($urandom)), 0);
            sent++;
        end

        // Random bursts: mixed, allocate-only and free-only runs on one class.
        while (sent < RANDOM_REQS) begin
            cls  = 2'($urandom_range(0, 3));
            kind = $urandom_range(0, 9);
            len  = $urandom_range(3, 24);
            calm = ($urandom_range(0, 3) == 0);
            cnt  = pool_scoreboard::blocks_in(cls);
            for (int k = 0; k < len && sent < RANDOM_REQS; k++) begin
                if (kind < 4) begin
                    mode = ($urandom_range(0, 9) < 6) ? sbpa_pkg::MODE_ALLOC
                                                      : sbpa_pkg::MODE_FREE;
                end else if (kind < 7) begin
                    mode = sbpa_pkg::MODE_ALLOC;
                end else begin
                    mode = sbpa_pkg::MODE_FREE;
                end
                if (mode == sbpa_pkg::MODE_FREE && $urandom_range(0, 9) != 0) begin
                    idx = 8'($urandom_range(0, cnt - 1));
                end else begin
                    idx = 8'($urandom);
                end
                push_req(req_of(mode, cls, idx), pick_gap(calm));
                sent++;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (sb.pending_rsp.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (!sb.failed && sb.pending_rsp.size() == 0) begin
            $display("segregated_block_pool_allocator_unit_tb: PASS");
        end else begin
            $display("segregated_block_pool_allocator_unit_tb: FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5000000;
        $display("segregated_block_pool_allocator_unit_tb: FAIL");
        $finish;
    end

endmodule
